@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCFL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define SCFL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/scfl_pkg.sv @@
// ----------------------------------------------------------------------------
// scfl_pkg
// shared widths, defaults and transaction types of the sector cache directory
// ----------------------------------------------------------------------------
package scfl_pkg;

    localparam int ADDR_W          = 48;
    localparam int CFG_W           = 32;
    localparam int NUM_PARTS       = 4;
    localparam int PART_W          = 2;
    localparam int SLOT_OUT_W      = 4;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_REG_COUNT   = 8;
    localparam int DEF_CACHE_SLOTS = 16;

    // probe that walks the row of slot cells
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic [PART_W-1:0] part;
        logic [ADDR_W-1:0] ev_addr;
    } t_probe;

    // slot write broadcast to the row
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PART_W-1:0] part;
    } t_wr;

endpackage

@@ hw/rtl/scfl_cell.sv @@
// ----------------------------------------------------------------------------
// scfl_cell
// one directory slot: holds a tag and compares it against the passing probe
// ----------------------------------------------------------------------------
module scfl_cell import scfl_pkg::*; #(
    parameter int SLOT_W = 4,
    parameter int INDEX  = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_probe            i_probe,
    input  logic [SLOT_W-1:0] i_probe_slot,
    input  logic [SLOT_W-1:0] i_target,
    input  t_wr               i_wr,
    output t_probe            o_probe,
    output logic [SLOT_W-1:0] o_probe_slot
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [PART_W-1:0] r_part;
    t_probe            r_probe;
    logic [SLOT_W-1:0] r_probe_slot;
    t_probe            n_probe;
    logic [SLOT_W-1:0] n_probe_slot;
    logic              w_sel;

    assign w_sel = (i_target == MY_SLOT);

    always_comb begin
        n_probe      = i_probe;
        n_probe_slot = i_probe_slot;
        // first valid tag that matches claims the probe
        if (i_probe.valid && r_valid && !i_probe.hit && (r_addr == i_probe.addr)) begin
            n_probe.hit  = 1'b1;
            n_probe.part = r_part;
            n_probe_slot = MY_SLOT;
        end
        // pick up the victim tag on the way
        if (w_sel) begin
            n_probe.ev_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_probe      <= '0;
            r_probe_slot <= '0;
        end else begin
            r_probe      <= n_probe;
            r_probe_slot <= n_probe_slot;
            if (i_wr.en && w_sel) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_sel) begin
            r_addr <= i_wr.addr;
            r_part <= i_wr.part;
        end
    end

    assign o_probe      = r_probe;
    assign o_probe_slot = r_probe_slot;

endmodule

@@ hw/rtl/sector_cache_fifo_lookup_core.sv @@
// ----------------------------------------------------------------------------
// sector_cache_fifo_lookup_core
// fully associative directory of open disk sectors with fifo replacement
// ----------------------------------------------------------------------------
// Each input transaction carries a 48-bit absolute sector address and yields
// exactly one result transaction. A probe walks a row of CACHE_SLOTS slot
// cells, one cell per clock, comparing against every stored tag and picking
// up the tag of the next victim slot; in parallel the address is checked
// against the four partition ranges (base .. base+count-1, count of zero
// means unused, lowest partition wins). A hit returns the slot and the
// partition recorded when the sector was opened, with the address made
// relative to that partition's current base. A miss inside a partition takes
// the next free slot, or once the row is full evicts the oldest entry and
// reports its address, and asks for a fetch. An address in no partition
// returns invalid with all other fields zero and changes nothing. One
// transaction is handled at a time: the result is loaded once the probe has
// walked the cell row, and input ready returns in the same cycle the result
// appears, so a new transaction is not accepted before the last result is
// loaded. A result waits in the output register until taken, and a finished
// lookup holds until the output register is free. Reset clears the valid
// bit of every slot. The partition registers are to be written through
// the plain write port only while no transaction is in flight; the block
// itself does not enforce this. Indexes beyond the eighth register are
// ignored.
// ----------------------------------------------------------------------------
module sector_cache_fifo_lookup_core import scfl_pkg::*; #(
    parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADDR_W-1:0]     i_block_addr,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic                  o_invalid,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic [PART_W-1:0]     o_part_index,
    output logic [CFG_W-1:0]      o_relative_addr,
    output logic                  o_fetch,
    output logic                  o_evicted,
    output logic [ADDR_W-1:0]     o_evicted_addr
);

    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(CACHE_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_WALK,
        S_RESOLVE
    } t_state;

    // partition registers
    logic [CFG_W-1:0]  r_base  [NUM_PARTS];
    logic [CFG_W-1:0]  r_count [NUM_PARTS];

    // control and datapath registers
    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_fill;
    logic [SLOT_W-1:0] r_oldest;
    logic [NUM_PARTS-1:0] r_pmatch;
    logic [CFG_W-1:0]  r_prel [NUM_PARTS];
    t_probe            r_end;
    logic [SLOT_W-1:0] r_end_slot;

    // result registers
    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_invalid;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [PART_W-1:0]     r_part;
    logic [CFG_W-1:0]      r_rel;
    logic                  r_fetch;
    logic                  r_evicted;
    logic [ADDR_W-1:0]     r_ev_addr;

    // cell row wiring
    t_probe            w_probe [CACHE_SLOTS+1];
    logic [SLOT_W-1:0] w_pslot [CACHE_SLOTS+1];
    t_wr               w_wr;

    logic              w_full;
    logic [SLOT_W-1:0] w_target;
    logic [ADDR_W:0]   w_pdiff [NUM_PARTS];
    logic [NUM_PARTS-1:0] w_pmatch;
    logic              w_any;
    logic [PART_W-1:0] w_first;
    logic [CFG_W-1:0]  w_hit_rel;
    logic              w_out_free;
    logic              w_fire;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_hit_slot_ext;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_tgt_slot_ext;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PARTS; p++) begin
                r_base[p]  <= '0;
                r_count[p] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(CFG_REG_COUNT))) begin
            // even index is a base, odd index a count
            if (i_cfg_index[0]) begin
                r_count[i_cfg_index[PART_W:1]] <= i_cfg_data;
            end else begin
                r_base[i_cfg_index[PART_W:1]] <= i_cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // fifo slot selection: while filling, oldest stays at zero
    // ------------------------------------------------------------------
    assign w_full   = (r_fill == CNT_W'(CACHE_SLOTS));
    assign w_target = w_full ? r_oldest : r_fill[SLOT_W-1:0];

    // ------------------------------------------------------------------
    // partition range check, one subtract and compare per partition
    // ------------------------------------------------------------------
    always_comb begin
        for (int p = 0; p < NUM_PARTS; p++) begin
            w_pdiff[p]  = {1'b0, r_addr} - {{(ADDR_W+1-CFG_W){1'b0}}, r_base[p]};
            // no borrow, upper bits clear, low bits below the count
            w_pmatch[p] = (r_count[p] != '0) && !w_pdiff[p][ADDR_W]
                          && (w_pdiff[p][ADDR_W-1:CFG_W] == '0)
                          && (w_pdiff[p][CFG_W-1:0] < r_count[p]);
        end
    end

    // lowest matching partition wins
    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        for (int p = NUM_PARTS - 1; p >= 0; p--) begin
            if (r_pmatch[p]) begin
                w_any   = 1'b1;
                w_first = PART_W'(p);
            end
        end
    end

    // on a hit the offset uses the recorded partition's current base
    assign w_hit_rel = r_addr[CFG_W-1:0] - r_base[r_end.part];

    assign w_hit_slot_ext = {{SLOT_OUT_W{1'b0}}, r_end_slot};
    assign w_tgt_slot_ext = {{SLOT_OUT_W{1'b0}}, w_target};

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = (r_state == S_RESOLVE) && w_out_free;

    // insert on a miss that lands in a partition
    assign w_wr.en   = w_fire && !r_end.hit && w_any;
    assign w_wr.addr = r_addr;
    assign w_wr.part = w_first;

    // ------------------------------------------------------------------
    // row of slot cells, probe enters at cell zero
    // ------------------------------------------------------------------
    assign w_probe[0] = '{valid:   (r_state == S_LAUNCH),
                          addr:    r_addr,
                          hit:     1'b0,
                          part:    '0,
                          ev_addr: '0};
    assign w_pslot[0] = '0;

    for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
        scfl_cell #(
            .SLOT_W (SLOT_W),
            .INDEX  (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_probe      (w_probe[g]),
            .i_probe_slot (w_pslot[g]),
            .i_target     (w_target),
            .i_wr         (w_wr),
            .o_probe      (w_probe[g+1]),
            .o_probe_slot (w_pslot[g+1])
        );
    end

    // ------------------------------------------------------------------
    // sequencer, fifo pointers and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken and no new one loaded
            if (i_out_ready && !w_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_addr  <= i_block_addr;
                        r_state <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    // probe enters the row, partition check is captured
                    r_pmatch <= w_pmatch;
                    for (int p = 0; p < NUM_PARTS; p++) begin
                        r_prel[p] <= w_pdiff[p][CFG_W-1:0];
                    end
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (w_probe[CACHE_SLOTS].valid) begin
                        r_end      <= w_probe[CACHE_SLOTS];
                        r_end_slot <= w_pslot[CACHE_SLOTS];
                        r_state    <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_end.hit) begin
                            r_hit     <= 1'b1;
                            r_invalid <= 1'b0;
                            r_slot    <= w_hit_slot_ext[SLOT_OUT_W-1:0];
                            r_part    <= r_end.part;
                            r_rel     <= w_hit_rel;
                            r_fetch   <= 1'b0;
                            r_evicted <= 1'b0;
                            r_ev_addr <= '0;
                        end else if (!w_any) begin
                            // outside every partition, nothing inserted
                            r_hit     <= 1'b0;
                            r_invalid <= 1'b1;
                            r_slot    <= '0;
                            r_part    <= '0;
                            r_rel     <= '0;
                            r_fetch   <= 1'b0;
                            r_evicted <= 1'b0;
                            r_ev_addr <= '0;
                        end else begin
                            r_hit     <= 1'b0;
                            r_invalid <= 1'b0;
                            r_slot    <= w_tgt_slot_ext[SLOT_OUT_W-1:0];
                            r_part    <= w_first;
                            r_rel     <= r_prel[w_first];
                            r_fetch   <= 1'b1;
                            if (w_full) begin
                                r_evicted <= 1'b1;
                                r_ev_addr <= r_end.ev_addr;
                                r_oldest  <= (r_oldest == SLOT_W'(CACHE_SLOTS - 1)) ?
                                             '0 : r_oldest + 1'b1;
                            end else begin
                                r_evicted <= 1'b0;
                                r_ev_addr <= '0;
                                r_fill    <= r_fill + 1'b1;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_invalid       = r_invalid;
    assign o_slot          = r_slot;
    assign o_part_index    = r_part;
    assign o_relative_addr = r_rel;
    assign o_fetch         = r_fetch;
    assign o_evicted       = r_evicted;
    assign o_evicted_addr  = r_ev_addr;

endmodule

@@ hw/rtl/scfl_checker.sv @@
// ----------------------------------------------------------------------------
// scfl_checker
// port-level checks of the sector cache directory, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfl_checker import scfl_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_W-1:0]      i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic [ADDR_W-1:0]     i_block_addr,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_hit,
    input logic                  o_invalid,
    input logic [SLOT_OUT_W-1:0] o_slot,
    input logic [PART_W-1:0]     o_part_index,
    input logic [CFG_W-1:0]      o_relative_addr,
    input logic                  o_fetch,
    input logic                  o_evicted,
    input logic [ADDR_W-1:0]     o_evicted_addr
);

    // a pending result is not dropped
    `SCFL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // one transaction in flight: ready drops after an accept
    `SCFL_ASSERT_NXT(a_one_inflight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a hit never asks for a fetch
    `SCFL_ASSERT_IMP(a_hit_no_fetch, i_clk, i_rst_n, o_out_valid && o_hit, !o_fetch && !o_evicted)

    // an address outside all partitions reports nothing else
    `SCFL_ASSERT_IMP(a_invalid_clean, i_clk, i_rst_n, o_out_valid && o_invalid, !o_hit && !o_fetch && (o_evicted_addr == '0))

    // eviction only happens on an inserting miss
    `SCFL_ASSERT_IMP(a_evict_fetch, i_clk, i_rst_n, o_out_valid && o_evicted, o_fetch)

endmodule

bind sector_cache_fifo_lookup_core scfl_checker u_scfl_checker (.*);

@@ test/tb_sector_cache_fifo_lookup_core.sv @@
// ----------------------------------------------------------------------------
// tb_sector_cache_fifo_lookup_core
// self-checking bench for the open sector directory with fifo replacement
// ----------------------------------------------------------------------------
// Lookup transactions are driven through a valid/ready request channel and
// every result transaction is compared field by field against a behavioral
// copy of the directory kept inside the bench. A short directed part covers
// unused partitions, range edges, overlap, the full row with eviction and a
// hit after the partitions were moved; random phases follow, each with its
// own partition layout and a mix of working-set reuse, edge addresses and
// raw noise. Both channels idle in random bursts except in the last phases.
// ----------------------------------------------------------------------------
module tb_sector_cache_fifo_lookup_core;
    import scfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_SLOTS  = DEF_CACHE_SLOTS;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 125;
    localparam int CALM_PHASES  = 2;

    // register map of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PART0_BASE,
        REG_PART0_COUNT,
        REG_PART1_BASE,
        REG_PART1_COUNT,
        REG_PART2_BASE,
        REG_PART2_COUNT,
        REG_PART3_BASE,
        REG_PART3_COUNT
    } part_reg_e;

    // one lookup outcome, same fields as the result channel
    typedef struct packed {
        logic                  hit;
        logic                  invalid;
        logic [SLOT_OUT_W-1:0] slot;
        logic [PART_W-1:0]     part;
        logic [CFG_W-1:0]      rel;
        logic                  fetch;
        logic                  evicted;
        logic [ADDR_W-1:0]     ev_addr;
    } sector_result_t;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ADDR_W-1:0]     i_block_addr = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic                  o_invalid;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic [PART_W-1:0]     o_part_index;
    logic [CFG_W-1:0]      o_relative_addr;
    logic                  o_fetch;
    logic                  o_evicted;
    logic [ADDR_W-1:0]     o_evicted_addr;

    // mirror of the partition registers
    logic [CFG_W-1:0] range_base  [NUM_PARTS] = '{default: '0};
    logic [CFG_W-1:0] range_count [NUM_PARTS] = '{default: '0};
    // layout to be programmed by the next configuration pass
    logic [CFG_W-1:0] next_base   [NUM_PARTS] = '{default: '0};
    logic [CFG_W-1:0] next_count  [NUM_PARTS] = '{default: '0};

    // mirror of the directory row, cleared like the hardware at reset
    logic [ADDR_W-1:0] dir_addr  [CACHE_SLOTS] = '{default: '0};
    logic              dir_valid [CACHE_SLOTS] = '{default: 1'b0};
    logic [PART_W-1:0] dir_part  [CACHE_SLOTS] = '{default: '0};
    int                dir_oldest = 0;
    int                dir_fill   = 0;

    // lookups waiting to be driven, and outcomes waiting to be seen
    logic [ADDR_W-1:0] pending_lookups [$];
    sector_result_t    expected_results [$];
    logic [ADDR_W-1:0] expected_addrs [$];

    int lookups_queued = 0;
    int results_seen   = 0;
    int mismatches     = 0;

    // idling control, percent chance per opportunity of starting a burst
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int in_gap       = 0;
    int out_gap      = 0;
    logic in_taken   = 1'b0;

    sector_result_t observed;
    sector_result_t wanted;
    logic [ADDR_W-1:0] wanted_addr;

    sector_cache_fifo_lookup_core #(
        .CACHE_SLOTS(CACHE_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_block_addr   (i_block_addr),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_invalid      (o_invalid),
        .o_slot         (o_slot),
        .o_part_index   (o_part_index),
        .o_relative_addr(o_relative_addr),
        .o_fetch        (o_fetch),
        .o_evicted      (o_evicted),
        .o_evicted_addr (o_evicted_addr)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // directory predictor: one call per accepted request transaction, updates
    // the mirrored row and returns the outcome the block must report
    // ------------------------------------------------------------------------
    function automatic sector_result_t lookup_sector(input logic [ADDR_W-1:0] addr);
        sector_result_t    r;
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W:0]   lim;
        int                s, q, p, victim;
        r = '0;
        // tag match across all valid slots
        for (s = 0; s < CACHE_SLOTS; s++) begin
            if (dir_valid[s] && dir_addr[s] == addr) begin
                r.hit  = 1'b1;
                r.slot = s[SLOT_OUT_W-1:0];
                r.part = dir_part[s];
                // relative to the current base of the partition stored at open
                diff   = addr - {{(ADDR_W-CFG_W){1'b0}}, range_base[dir_part[s]]};
                r.rel  = diff[CFG_W-1:0];
                return r;
            end
        end
        // first partition whose range holds the address wins
        p = -1;
        for (q = 0; q < NUM_PARTS; q++) begin
            lim = {{(ADDR_W+1-CFG_W){1'b0}}, range_base[q]}
                + {{(ADDR_W+1-CFG_W){1'b0}}, range_count[q]};
            if (p < 0 && range_count[q] != 0 && addr >= range_base[q]
                    && {1'b0, addr} < lim) begin
                p = q;
            end
        end
        if (p < 0) begin
            // no partition: flag it and leave the row alone
            r.invalid = 1'b1;
            return r;
        end
        if (dir_fill < CACHE_SLOTS) begin
            victim   = (dir_oldest + dir_fill) % CACHE_SLOTS;
            dir_fill = dir_fill + 1;
        end else begin
            // row full: close the oldest entry and reuse its slot
            victim     = dir_oldest;
            r.evicted  = 1'b1;
            r.ev_addr  = dir_addr[victim];
            dir_oldest = (dir_oldest + 1) % CACHE_SLOTS;
        end
        dir_addr[victim]  = addr;
        dir_valid[victim] = 1'b1;
        dir_part[victim]  = p[PART_W-1:0];
        diff    = addr - {{(ADDR_W-CFG_W){1'b0}}, range_base[p]};
        r.slot  = victim[SLOT_OUT_W-1:0];
        r.part  = p[PART_W-1:0];
        r.rel   = diff[CFG_W-1:0];
        r.fetch = 1'b1;
        return r;
    endfunction

    function automatic string fmt_result(input sector_result_t r);
        return $sformatf("hit=%b inv=%b slot=%0d part=%0d rel=%h fetch=%b ev=%b ev_addr=%h",
                         r.hit, r.invalid, r.slot, r.part, r.rel,
                         r.fetch, r.evicted, r.ev_addr);
    endfunction

    // ------------------------------------------------------------------------
    // request driver: inputs move on the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : request_driver
        logic              nxt_valid;
        logic [ADDR_W-1:0] nxt_addr;
        nxt_valid = i_in_valid;
        nxt_addr  = i_block_addr;
        // transaction went through at the last rising edge
        if (i_in_valid && in_taken) begin
            nxt_valid = 1'b0;
        end
        if (!nxt_valid && i_rst_n && pending_lookups.size() > 0) begin
            if (in_gap > 0) begin
                in_gap = in_gap - 1;
            end else if ($urandom_range(0, 99) < in_idle_pct) begin
                // start an idle burst, this cycle included; bursts
                // chain so the gap can outlast the block's own busy time
                in_gap = $urandom_range(0, 11);
            end else begin
                nxt_valid = 1'b1;
                nxt_addr  = pending_lookups.pop_front();
            end
        end
        i_in_valid   <= nxt_valid;
        i_block_addr <= nxt_addr;
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap = out_gap - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            out_gap = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both channels sampled on the rising edge; the result side is
    // checked before a new request is predicted in the same cycle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            observed.hit     = o_hit;
            observed.invalid = o_invalid;
            observed.slot    = o_slot;
            observed.part    = o_part_index;
            observed.rel     = o_relative_addr;
            observed.fetch   = o_fetch;
            observed.evicted = o_evicted;
            observed.ev_addr = o_evicted_addr;
            results_seen = results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("[%0t] result with no lookup pending: %s",
                             $realtime, fmt_result(observed));
                end
            end else begin
                wanted      = expected_results.pop_front();
                wanted_addr = expected_addrs.pop_front();
                if (observed !== wanted) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("[%0t] mismatch for sector %h", $realtime, wanted_addr);
                        $display("    expected %s", fmt_result(wanted));
                        $display("    actual   %s", fmt_result(observed));
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_addrs.push_back(i_block_addr);
            expected_results.push_back(lookup_sector(i_block_addr));
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_lookup(input logic [ADDR_W-1:0] addr);
        pending_lookups.push_back(addr);
        lookups_queued = lookups_queued + 1;
    endtask

    // one register write per clock; the mirror follows as the write is issued
    task automatic write_part_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx < CFG_REG_COUNT) begin
            if (idx[0]) begin
                range_count[idx >> 1] = val;
            end else begin
                range_base[idx >> 1] = val;
            end
        end
    endtask

    // program every partition from next_base/next_count, optionally poking an
    // index past the register map, which the block must ignore
    task automatic apply_partitions(input bit with_stray);
        int q;
        for (q = 0; q < NUM_PARTS; q++) begin
            write_part_reg(REG_PART0_BASE + 2 * q, next_base[q]);
            write_part_reg(REG_PART0_COUNT + 2 * q, next_count[q]);
        end
        if (with_stray) begin
            write_part_reg($urandom_range(CFG_REG_COUNT, 2 ** CFG_IDX_W - 1), $urandom);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every queued lookup to come back, then let the core settle
    task automatic drain_lookups();
        while (results_seen < lookups_queued) begin
            @(negedge i_clk);
        end
        repeat (CACHE_SLOTS + 8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [ADDR_W-1:0] work_set [$];
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] b48;
        logic [63:0]       wide;
        logic [CFG_W-1:0]  off;
        int                ph, q, k, n, sel;
        bit                any_used;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all partitions unused after reset: everything is invalid
        in_idle_pct  = 30;
        out_idle_pct = 15;
        queue_lookup('0);
        queue_lookup({ADDR_W{1'b1}});
        drain_lookups();

        // p0 and p1 overlap, p2 sits at the top of the 32-bit base range with
        // the largest count, p3 holds a single sector
        next_base[0] = 32'h0000_0100;  next_count[0] = 32'h0000_0040;
        next_base[1] = 32'h0000_0120;  next_count[1] = 32'h0000_0100;
        next_base[2] = 32'hFFFF_FFFF;  next_count[2] = 32'hFFFF_FFFF;
        next_base[3] = 32'h4000_0000;  next_count[3] = 32'h0000_0001;
        apply_partitions(1'b1);
        queue_lookup(48'h0000_0000_0100);   // miss in p0
        queue_lookup(48'h0000_0000_0100);   // same sector again: hit
        queue_lookup(48'h0000_0000_013F);   // last sector of p0
        queue_lookup(48'h0000_0000_0140);   // first one only p1 holds
        queue_lookup(48'h0000_0000_0130);   // overlap, lower partition wins
        queue_lookup(48'h0000_0000_021F);   // last sector of p1
        queue_lookup(48'h0000_0000_0220);   // just past p1
        queue_lookup(48'h0000_0000_00FF);   // just below p0
        queue_lookup(48'h0000_FFFF_FFFF);   // p2 base
        queue_lookup(48'h0001_FFFF_FFFD);   // p2 end, above 32 bits
        queue_lookup(48'h0001_FFFF_FFFE);   // past p2
        queue_lookup(48'h0000_4000_0000);   // single sector partition
        queue_lookup(48'h0000_4000_0001);
        queue_lookup({ADDR_W{1'b1}});
        // fill the row, then keep going so the oldest entries get closed
        for (k = 1; k <= 9; k++) begin
            queue_lookup(48'h0000_0000_0100 + k);
        end
        queue_lookup(48'h0000_0000_0100);   // was evicted: miss again
        drain_lookups();

        // move p0 and p1 under open sectors: hits keep the stored partition,
        // relative address follows the new base and may wrap
        next_base[0] = 32'h0000_0200;  next_count[0] = 32'h0000_0001;
        next_base[1] = 32'h0000_0000;  next_count[1] = 32'h0000_0000;
        apply_partitions(1'b0);
        queue_lookup(48'h0000_0000_0101);
        queue_lookup(48'h0000_0000_0140);
        drain_lookups();

        // random phases with their own layout and traffic mix
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph >= RAND_PHASES - CALM_PHASES) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       in_idle_pct = 0;
                    1:       in_idle_pct = 20;
                    2:       in_idle_pct = 50;
                    default: in_idle_pct = 75;
                endcase
                case ($urandom_range(0, 3))
                    0:       out_idle_pct = 0;
                    1:       out_idle_pct = 5;
                    2:       out_idle_pct = 15;
                    default: out_idle_pct = 40;
                endcase
            end

            any_used = 1'b0;
            for (q = 0; q < NUM_PARTS; q++) begin
                case ($urandom_range(0, 5))
                    0: begin   // unused
                        next_base[q]  = $urandom;
                        next_count[q] = '0;
                    end
                    1: begin   // small window anywhere
                        next_base[q]  = $urandom;
                        next_count[q] = $urandom_range(1, 48);
                    end
                    2: begin   // wide window
                        next_base[q]  = $urandom;
                        next_count[q] = $urandom;
                    end
                    3: begin   // top of both ranges
                        next_base[q]  = '1;
                        next_count[q] = '1;
                    end
                    4: begin   // starts at sector zero
                        next_base[q]  = '0;
                        next_count[q] = $urandom_range(1, 200);
                    end
                    default: begin   // overlaps the partition below
                        next_base[q]  = (q > 0) ? next_base[q-1] + $urandom_range(0, 8)
                                                : $urandom;
                        next_count[q] = $urandom_range(1, 64);
                    end
                endcase
                if (next_count[q] != 0) any_used = 1'b1;
            end
            if (!any_used) begin
                next_count[$urandom_range(0, NUM_PARTS - 1)] = $urandom_range(1, 32);
            end
            apply_partitions($urandom_range(0, 3) == 0);

            // working set drawn from the used partitions; its size decides
            // whether the phase is mostly hits or mostly evictions
            work_set.delete();
            n = $urandom_range(4, 30);
            for (k = 0; k < n; k++) begin
                do q = $urandom_range(0, NUM_PARTS - 1); while (range_count[q] == 0);
                off = (range_count[q] <= 64) ? $urandom_range(0, range_count[q] - 1)
                                             : $urandom % range_count[q];
                work_set.push_back({{(ADDR_W-CFG_W){1'b0}}, range_base[q]}
                                   + {{(ADDR_W-CFG_W){1'b0}}, off});
            end

            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 80) begin
                    addr = work_set[$urandom_range(0, work_set.size() - 1)];
                end else if (sel < 90) begin
                    // just inside or just outside a partition edge
                    q   = $urandom_range(0, NUM_PARTS - 1);
                    b48 = {{(ADDR_W-CFG_W){1'b0}}, range_base[q]};
                    case ($urandom_range(0, 3))
                        0:       addr = b48 - 1;
                        1:       addr = b48;
                        2:       addr = b48 + range_count[q] - 1;
                        default: addr = b48 + range_count[q];
                    endcase
                end else begin
                    wide = {$urandom, $urandom};
                    addr = $urandom_range(0, 1) ? wide[ADDR_W-1:0]
                                                : {15'b0, wide[32:0]};
                end
                queue_lookup(addr);
            end
            drain_lookups();
        end

        if (expected_results.size() != 0) begin
            mismatches = mismatches + expected_results.size();
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
